>>> rtl/amgs_pkg.sv
// package for the adjacency matrix graph store
// request codes, error codes, sizes and the result beat type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package amgs_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int ID_W         = 6;
	localparam int COUNT_W      = 7;
	localparam int ROWS         = 64;

	localparam logic [2:0] FUNC_ADD_VERTEX  = 3'd0;
	localparam logic [2:0] FUNC_INSERT_EDGE = 3'd1;
	localparam logic [2:0] FUNC_REMOVE_EDGE = 3'd2;
	localparam logic [2:0] FUNC_TEST_EDGE   = 3'd3;
	localparam logic [2:0] FUNC_SUCCESSORS  = 3'd4;
	localparam logic [2:0] FUNC_PREDECESSORS = 3'd5;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_RANGE = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0] vertex_id;
		logic            edge_found;
		logic            empty_list;
		logic [1:0]      error_code;
		logic            last;
	} result_t;

	function automatic result_t make_result(input logic [ID_W-1:0] id, input logic found,
			input logic empty, input logic [1:0] err, input logic fin);
		result_t r;
		r.vertex_id  = id;
		r.edge_found = found;
		r.empty_list = empty;
		r.error_code = err;
		r.last       = fin;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/adjacency_matrix_graph_store.sv
// adjacency matrix graph store: top level with sequencer and matrix memory
// depends on amgs_pkg
//
// Use: a request (func, vertex_a, vertex_b) is taken on a clock edge with start high
// and busy low. Results leave as one-cycle beats marked by result_valid; the
// receiver cannot hold them off, and the final beat of a request carries last.
// The directed_graph register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// Add vertex, undefined codes and range errors are answered from the decode state;
// test edge and directed insert/remove after the row-A read; undirected insert/remove
// go on through the wait and row-B states (two read-modify-writes of one row port).
// Successor listing reads row a and scans it; predecessor listing first gathers the
// column one row read per cycle before the scan. The scan over the gathered bits is
// one shift a cycle, so neighbour beats come at most one a cycle, each held back
// until the next one (or the end of the scan) is known, which sets the last marker.
// busy stays high until the final beat is registered; a new request may be taken
// in the cycle that beat is on the ports.
// Reset clears the vertex count, the register and the per-row valid bits, so every
// row reads as empty at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_graph_store (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [2:0]                   func,
	input  wire  [amgs_pkg::ID_W-1:0]    vertex_a,
	input  wire  [amgs_pkg::ID_W-1:0]    vertex_b,
	input  wire                          cfg_wr_en,
	input  wire                          cfg_wr_data,
	output logic                         result_valid,
	output logic [amgs_pkg::ID_W-1:0]    vertex_id,
	output logic                         edge_found,
	output logic                         empty_list,
	output logic [1:0]                   error_code,
	output logic                         last
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_ROW_A  = 3'd2;
	localparam logic [2:0] ST_WAIT_B = 3'd3;
	localparam logic [2:0] ST_ROW_B  = 3'd4;
	localparam logic [2:0] ST_COL    = 3'd5;
	localparam logic [2:0] ST_SCAN   = 3'd6;

	logic [2:0]                          state_q;
	logic [2:0]                          func_q;
	logic [amgs_pkg::ID_W-1:0]           a_q;
	logic [amgs_pkg::ID_W-1:0]           b_q;
	logic [amgs_pkg::COUNT_W-1:0]        vc_q;
	logic [amgs_pkg::COUNT_W-1:0]        idx_q;
	logic                                directed_q;
	logic [amgs_pkg::ROWS-1:0]           row_vld_q;
	logic [amgs_pkg::ROWS-1:0]           list_q;
	logic                                have_q;
	logic [amgs_pkg::ID_W-1:0]           pend_id_q;
	amgs_pkg::result_t                   res_q;
	logic                                res_vld_q;

	logic [amgs_pkg::ROWS-1:0]           mem [amgs_pkg::ROWS];
	logic [amgs_pkg::ROWS-1:0]           mem_rd_s1;
	logic                                rd_vld_s1;
	logic                                rd_pend_s1;
	logic [amgs_pkg::ID_W-1:0]           rd_idx_s1;

	logic [amgs_pkg::ID_W-1:0]           rd_addr;
	logic [amgs_pkg::ID_W-1:0]           wr_addr;
	logic [amgs_pkg::ROWS-1:0]           wr_data;
	logic                                mem_we;
	logic [amgs_pkg::ROWS-1:0]           rd_row;
	logic [amgs_pkg::ROWS-1:0]           bit_a;
	logic [amgs_pkg::ROWS-1:0]           bit_b;
	logic                                a_ok;
	logic                                b_ok;
	logic                                scan_more;
	logic                                is_insert;

	always_comb begin
		a_ok      = {1'b0, a_q} < vc_q;
		b_ok      = {1'b0, b_q} < vc_q;
		scan_more = idx_q < vc_q;
		is_insert = func_q == amgs_pkg::FUNC_INSERT_EDGE;
		rd_row    = rd_vld_s1 ? mem_rd_s1 : '0;
		bit_a     = {{(amgs_pkg::ROWS-1){1'b0}}, 1'b1} << a_q;
		bit_b     = {{(amgs_pkg::ROWS-1){1'b0}}, 1'b1} << b_q;
		mem_we    = 1'b0;
		wr_addr   = a_q;
		wr_data   = rd_row;
		case (state_q)
			ST_WAIT_B: rd_addr = b_q;
			ST_COL:    rd_addr = idx_q[amgs_pkg::ID_W-1:0];
			default:   rd_addr = a_q;
		endcase
		case (state_q)
			ST_ROW_A: begin
				if (func_q == amgs_pkg::FUNC_INSERT_EDGE || func_q == amgs_pkg::FUNC_REMOVE_EDGE) begin
					mem_we  = 1'b1;
					wr_data = is_insert ? (rd_row | bit_b) : (rd_row & ~bit_b);
				end
			end
			ST_ROW_B: begin
				mem_we  = 1'b1;
				wr_addr = b_q;
				wr_data = is_insert ? (rd_row | bit_a) : (rd_row & ~bit_a);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// matrix rows, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		mem_rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			func_q     <= '0;
			a_q        <= '0;
			b_q        <= '0;
			vc_q       <= '0;
			idx_q      <= '0;
			directed_q <= 1'b0;
			row_vld_q  <= '0;
			list_q     <= '0;
			have_q     <= 1'b0;
			pend_id_q  <= '0;
			res_q      <= '0;
			res_vld_q  <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_pend_s1 <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			res_vld_q  <= 1'b0;
			rd_pend_s1 <= 1'b0;
			rd_vld_s1  <= row_vld_q[rd_addr];
			if (cfg_wr_en) begin
				directed_q <= cfg_wr_data;
			end
			if (mem_we) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			// column gather: bit a of the row read last cycle
			if (rd_pend_s1) begin
				list_q[rd_idx_s1] <= rd_row[a_q];
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q  <= func;
						a_q     <= vertex_a;
						b_q     <= vertex_b;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					have_q <= 1'b0;
					idx_q  <= '0;
					case (func_q)
						amgs_pkg::FUNC_ADD_VERTEX: begin
							res_vld_q <= 1'b1;
							state_q   <= ST_IDLE;
							if (vc_q >= amgs_pkg::COUNT_W'(amgs_pkg::MAX_VERTICES)) begin
								res_q <= amgs_pkg::make_result('0, 1'b0, 1'b0,
									amgs_pkg::ERR_FULL, 1'b1);
							end else begin
								res_q <= amgs_pkg::make_result(vc_q[amgs_pkg::ID_W-1:0],
									1'b0, 1'b0, amgs_pkg::ERR_OK, 1'b1);
								vc_q  <= vc_q + 1'b1;
							end
						end
						amgs_pkg::FUNC_INSERT_EDGE, amgs_pkg::FUNC_REMOVE_EDGE,
						amgs_pkg::FUNC_TEST_EDGE: begin
							if (!a_ok || !b_ok) begin
								res_vld_q <= 1'b1;
								res_q     <= amgs_pkg::make_result('0, 1'b0, 1'b0,
									amgs_pkg::ERR_RANGE, 1'b1);
								state_q   <= ST_IDLE;
							end else begin
								state_q <= ST_ROW_A;
							end
						end
						amgs_pkg::FUNC_SUCCESSORS, amgs_pkg::FUNC_PREDECESSORS: begin
							if (!a_ok) begin
								res_vld_q <= 1'b1;
								res_q     <= amgs_pkg::make_result('0, 1'b0, 1'b0,
									amgs_pkg::ERR_RANGE, 1'b1);
								state_q   <= ST_IDLE;
							end else if (func_q == amgs_pkg::FUNC_SUCCESSORS) begin
								state_q <= ST_ROW_A;
							end else begin
								state_q <= ST_COL;
							end
						end
						default: begin
							res_vld_q <= 1'b1;
							res_q     <= amgs_pkg::make_result('0, 1'b0, 1'b0,
								amgs_pkg::ERR_OK, 1'b1);
							state_q   <= ST_IDLE;
						end
					endcase
				end
				ST_ROW_A: begin
					case (func_q)
						amgs_pkg::FUNC_TEST_EDGE: begin
							res_vld_q <= 1'b1;
							res_q     <= amgs_pkg::make_result('0, rd_row[b_q], 1'b0,
								amgs_pkg::ERR_OK, 1'b1);
							state_q   <= ST_IDLE;
						end
						amgs_pkg::FUNC_SUCCESSORS: begin
							list_q  <= rd_row;
							state_q <= ST_SCAN;
						end
						default: begin
							// insert or remove: row a is written this cycle
							if (directed_q) begin
								res_vld_q <= 1'b1;
								res_q     <= amgs_pkg::make_result('0, 1'b0, 1'b0,
									amgs_pkg::ERR_OK, 1'b1);
								state_q   <= ST_IDLE;
							end else begin
								state_q <= ST_WAIT_B;
							end
						end
					endcase
				end
				ST_WAIT_B: begin
					state_q <= ST_ROW_B;
				end
				ST_ROW_B: begin
					res_vld_q <= 1'b1;
					res_q     <= amgs_pkg::make_result('0, 1'b0, 1'b0, amgs_pkg::ERR_OK, 1'b1);
					state_q   <= ST_IDLE;
				end
				ST_COL: begin
					if (scan_more) begin
						rd_pend_s1 <= 1'b1;
						rd_idx_s1  <= idx_q[amgs_pkg::ID_W-1:0];
						idx_q      <= idx_q + 1'b1;
					end else if (!rd_pend_s1) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_more) begin
						// a hit releases the neighbour held from before
						if (list_q[0]) begin
							if (have_q) begin
								res_vld_q <= 1'b1;
								res_q     <= amgs_pkg::make_result(pend_id_q, 1'b0, 1'b0,
									amgs_pkg::ERR_OK, 1'b0);
							end
							have_q    <= 1'b1;
							pend_id_q <= idx_q[amgs_pkg::ID_W-1:0];
						end
						list_q <= list_q >> 1;
						idx_q  <= idx_q + 1'b1;
					end else begin
						res_vld_q <= 1'b1;
						if (have_q) begin
							res_q <= amgs_pkg::make_result(pend_id_q, 1'b0, 1'b0,
								amgs_pkg::ERR_OK, 1'b1);
						end else begin
							res_q <= amgs_pkg::make_result('0, 1'b0, 1'b1,
								amgs_pkg::ERR_OK, 1'b1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign result_valid = res_vld_q;
	assign vertex_id    = res_q.vertex_id;
	assign edge_found   = res_q.edge_found;
	assign empty_list   = res_q.empty_list;
	assign error_code   = res_q.error_code;
	assign last         = res_q.last;

`ifndef ASSERT_OFF
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	a_more_to_come: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final beat while the sequencer is idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vc_q <= amgs_pkg::COUNT_W'(amgs_pkg::MAX_VERTICES))
		else $error("vertex count beyond the store size");

	a_empty_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && empty_list |-> last && error_code == amgs_pkg::ERR_OK)
		else $error("empty listing beat not final or flagged as an error");
`endif

endmodule

`default_nettype wire
